/* hw/rtl/z80sc_pkg.sv */
package z80sc_pkg;

  localparam int MemBytesDef = 65536;
  localparam logic [15:0] ResetPcDef = 16'h0000;
  localparam logic [15:0] ResetSpDef = 16'hffff;

  localparam logic CFG_RESET_PC = 1'b0;
  localparam logic CFG_RESET_SP = 1'b1;

  localparam logic [7:0] FL_S  = 8'h80;
  localparam logic [7:0] FL_Z  = 8'h40;
  localparam logic [7:0] FL_H  = 8'h10;
  localparam logic [7:0] FL_PV = 8'h04;
  localparam logic [7:0] FL_N  = 8'h02;
  localparam logic [7:0] FL_C  = 8'h01;

  localparam logic [2:0] R_HL_MEM = 3'd6;
  localparam logic [2:0] R_A      = 3'd7;

  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_XOR = 3'd5;
  localparam logic [2:0] ALU_OR  = 3'd6;
  localparam logic [2:0] ALU_CP  = 3'd7;

  typedef enum logic [4:0] {
    C_NOP, C_HALT, C_LDRN, C_INCDEC, C_LDRR, C_ALU, C_ALUI, C_LD16, C_LDAM, C_LDMA,
    C_JP, C_JPCC, C_JR, C_JRCC, C_CALL, C_RET, C_IN, C_OUT, C_BAD
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [1:0] nops;
    logic       rd_hl;
    logic       wr_hl;
  } dec_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_F1, ST_DEC, ST_O1, ST_O2, ST_AO, ST_M1, ST_R1, ST_R2,
    ST_EX, ST_C2, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    AS_PC, AS_HL, AS_NN, AS_SP, AS_SPM1, AS_LOAD, AS_CLR
  } addr_sel_t;

  typedef enum logic [2:0] {
    WD_ZERO, WD_LOAD, WD_RES, WD_A, WD_PCH, WD_PCL
  } wd_sel_t;

  typedef enum logic [2:0] {
    LAT_NONE, LAT_IR, LAT_LO, LAT_HI, LAT_MDR
  } lat_t;

  typedef struct packed {
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t asel;
    wd_sel_t   wsel;
    lat_t      lat;
    logic      pc_inc;
    logic      sp_inc;
    logic      sp_dec;
    logic      start;
    logic      exec;
    logic      call_jump;
    logic      out_load;
    logic      clr_step;
  } cmd_t;

  typedef struct packed {
    dec_t dec;
    logic halted;
    logic clr_last;
  } sts_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    logic [2:0] y;
    logic [2:0] z;
    y = op[5:3];
    z = op[2:0];
    d.cls = C_BAD;
    d.nops = 2'd0;
    d.rd_hl = 1'b0;
    d.wr_hl = 1'b0;
    priority if (op == 8'h76) begin
      d.cls = C_HALT;
    end else if ((op & 8'hc7) == 8'h06) begin
      d.cls = C_LDRN;
      d.nops = 2'd1;
      d.wr_hl = (y == R_HL_MEM);
    end else if ((op & 8'hc7) == 8'h04 || (op & 8'hc7) == 8'h05) begin
      d.cls = C_INCDEC;
      d.rd_hl = (y == R_HL_MEM);
      d.wr_hl = (y == R_HL_MEM);
    end else if (op[7:6] == 2'b01) begin
      d.cls = C_LDRR;
      d.rd_hl = (z == R_HL_MEM);
      d.wr_hl = (y == R_HL_MEM);
    end else if (op[7:6] == 2'b10 && y != 3'd1 && y != 3'd3) begin
      d.cls = C_ALU;
      d.rd_hl = (z == R_HL_MEM);
    end else begin
      unique case (op)
        8'h00, 8'hf3, 8'hfb: d.cls = C_NOP;
        8'h01, 8'h11, 8'h21, 8'h31: begin d.cls = C_LD16; d.nops = 2'd2; end
        8'h3a: begin d.cls = C_LDAM; d.nops = 2'd2; end
        8'h32: begin d.cls = C_LDMA; d.nops = 2'd2; end
        8'hc3: begin d.cls = C_JP; d.nops = 2'd2; end
        8'hc2, 8'hca, 8'hd2, 8'hda, 8'he2, 8'hea, 8'hf2, 8'hfa: begin
          d.cls = C_JPCC; d.nops = 2'd2;
        end
        8'h18: begin d.cls = C_JR; d.nops = 2'd1; end
        8'h20, 8'h28, 8'h30, 8'h38: begin d.cls = C_JRCC; d.nops = 2'd1; end
        8'hcd: begin d.cls = C_CALL; d.nops = 2'd2; end
        8'hc9: d.cls = C_RET;
        8'hc6, 8'hd6, 8'he6, 8'hee, 8'hf6, 8'hfe: begin d.cls = C_ALUI; d.nops = 2'd1; end
        8'hdb: begin d.cls = C_IN; d.nops = 2'd1; end
        8'hd3: begin d.cls = C_OUT; d.nops = 2'd1; end
        default: d.cls = C_BAD;
      endcase
    end
    return d;
  endfunction

endpackage

/* hw/rtl/z80sc_ram.sv */
module z80sc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/z80sc_ctrl.sv */
module z80sc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_opcode,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  z80sc_pkg::sts_t sts,
  output z80sc_pkg::cmd_t cmd
);

  z80sc_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != z80sc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      z80sc_pkg::ST_CLR: if (sts.clr_last) state_nxt = z80sc_pkg::ST_IDLE;
      z80sc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode || sts.halted) state_nxt = z80sc_pkg::ST_DONE;
          else state_nxt = z80sc_pkg::ST_F1;
        end
      end
      z80sc_pkg::ST_F1: state_nxt = z80sc_pkg::ST_DEC;
      z80sc_pkg::ST_DEC: begin
        state_nxt = (sts.dec.nops != 2'd0) ? z80sc_pkg::ST_O1 : z80sc_pkg::ST_AO;
      end
      z80sc_pkg::ST_O1: begin
        state_nxt = (sts.dec.nops == 2'd2) ? z80sc_pkg::ST_O2 : z80sc_pkg::ST_AO;
      end
      z80sc_pkg::ST_O2: state_nxt = z80sc_pkg::ST_AO;
      z80sc_pkg::ST_AO: begin
        priority if (sts.dec.cls == z80sc_pkg::C_RET) state_nxt = z80sc_pkg::ST_R1;
        else if (sts.dec.rd_hl || sts.dec.cls == z80sc_pkg::C_LDAM)
          state_nxt = z80sc_pkg::ST_M1;
        else state_nxt = z80sc_pkg::ST_EX;
      end
      z80sc_pkg::ST_R1: state_nxt = z80sc_pkg::ST_R2;
      z80sc_pkg::ST_R2: state_nxt = z80sc_pkg::ST_EX;
      z80sc_pkg::ST_M1: state_nxt = z80sc_pkg::ST_EX;
      z80sc_pkg::ST_EX: begin
        state_nxt = (sts.dec.cls == z80sc_pkg::C_CALL) ? z80sc_pkg::ST_C2
                                                       : z80sc_pkg::ST_DONE;
      end
      z80sc_pkg::ST_C2: state_nxt = z80sc_pkg::ST_DONE;
      z80sc_pkg::ST_DONE: if (out_free) state_nxt = z80sc_pkg::ST_IDLE;
      default: state_nxt = z80sc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.asel = z80sc_pkg::AS_PC;
    cmd.wsel = z80sc_pkg::WD_ZERO;
    cmd.lat = z80sc_pkg::LAT_NONE;
    unique case (state_r)
      z80sc_pkg::ST_CLR: begin
        cmd.mem_wr = 1'b1;
        cmd.asel = z80sc_pkg::AS_CLR;
        cmd.clr_step = 1'b1;
      end
      z80sc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_opcode) begin
            cmd.mem_wr = 1'b1;
            cmd.asel = z80sc_pkg::AS_LOAD;
            cmd.wsel = z80sc_pkg::WD_LOAD;
          end else if (!sts.halted) begin
            cmd.mem_rd = 1'b1;
            cmd.pc_inc = 1'b1;
          end
        end
      end
      z80sc_pkg::ST_F1: cmd.lat = z80sc_pkg::LAT_IR;
      z80sc_pkg::ST_DEC: begin
        if (sts.dec.nops != 2'd0) begin
          cmd.mem_rd = 1'b1;
          cmd.pc_inc = 1'b1;
        end
      end
      z80sc_pkg::ST_O1: begin
        cmd.lat = z80sc_pkg::LAT_LO;
        if (sts.dec.nops == 2'd2) begin
          cmd.mem_rd = 1'b1;
          cmd.pc_inc = 1'b1;
        end
      end
      z80sc_pkg::ST_O2: cmd.lat = z80sc_pkg::LAT_HI;
      z80sc_pkg::ST_AO: begin
        priority if (sts.dec.cls == z80sc_pkg::C_RET) begin
          cmd.mem_rd = 1'b1;
          cmd.asel = z80sc_pkg::AS_SP;
          cmd.sp_inc = 1'b1;
        end else if (sts.dec.rd_hl) begin
          cmd.mem_rd = 1'b1;
          cmd.asel = z80sc_pkg::AS_HL;
        end else if (sts.dec.cls == z80sc_pkg::C_LDAM) begin
          cmd.mem_rd = 1'b1;
          cmd.asel = z80sc_pkg::AS_NN;
        end else begin
          cmd.mem_rd = 1'b0;
        end
      end
      z80sc_pkg::ST_R1: begin
        cmd.lat = z80sc_pkg::LAT_LO;
        cmd.mem_rd = 1'b1;
        cmd.asel = z80sc_pkg::AS_SP;
        cmd.sp_inc = 1'b1;
      end
      z80sc_pkg::ST_R2: cmd.lat = z80sc_pkg::LAT_HI;
      z80sc_pkg::ST_M1: cmd.lat = z80sc_pkg::LAT_MDR;
      z80sc_pkg::ST_EX: begin
        cmd.exec = 1'b1;
        priority if (sts.dec.wr_hl) begin
          cmd.mem_wr = 1'b1;
          cmd.asel = z80sc_pkg::AS_HL;
          cmd.wsel = z80sc_pkg::WD_RES;
        end else if (sts.dec.cls == z80sc_pkg::C_LDMA) begin
          cmd.mem_wr = 1'b1;
          cmd.asel = z80sc_pkg::AS_NN;
          cmd.wsel = z80sc_pkg::WD_A;
        end else if (sts.dec.cls == z80sc_pkg::C_CALL) begin
          cmd.mem_wr = 1'b1;
          cmd.asel = z80sc_pkg::AS_SPM1;
          cmd.wsel = z80sc_pkg::WD_PCH;
          cmd.sp_dec = 1'b1;
        end else begin
          cmd.mem_wr = 1'b0;
        end
      end
      z80sc_pkg::ST_C2: begin
        cmd.mem_wr = 1'b1;
        cmd.asel = z80sc_pkg::AS_SPM1;
        cmd.wsel = z80sc_pkg::WD_PCL;
        cmd.sp_dec = 1'b1;
        cmd.call_jump = 1'b1;
      end
      z80sc_pkg::ST_DONE: cmd.out_load = out_free;
      default: cmd.mem_rd = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= z80sc_pkg::ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/z80sc_dp.sv */
module z80sc_dp #(
  parameter int MemBytes = z80sc_pkg::MemBytesDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  z80sc_pkg::cmd_t cmd,
  output z80sc_pkg::sts_t sts,
  input  logic [15:0]     in_load_address,
  input  logic [7:0]      in_load_data,
  input  logic [7:0]      in_io_read_data,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [15:0]     cfg_wdata,
  output logic [4:0]      out_cycles,
  output logic            out_halted,
  output logic            out_fault,
  output logic            out_io_read_done,
  output logic            out_io_write_valid,
  output logic [7:0]      out_io_port,
  output logic [7:0]      out_io_write_data,
  output logic [15:0]     out_pc_now
);

  localparam int AW = $clog2(MemBytes);

  logic [7:0] a_r, f_r, b_r, c_r, d_r, e_r, h_r, l_r;
  logic [15:0] pc_r, sp_r;
  logic halt_r;
  logic [7:0] ir_r, lo_r, hi_r, mdr_r, iod_r;
  logic [AW-1:0] clr_r;
  logic [4:0] cyc_r;
  logic flt_r, iord_r, iowr_r;
  logic [7:0] port_r, wdat_r;
  logic [4:0] o_cyc_r;
  logic o_halt_r, o_flt_r, o_iord_r, o_iowr_r;
  logic [7:0] o_port_r, o_wdat_r;
  logic [15:0] o_pc_r;

  z80sc_pkg::dec_t dec;
  logic [2:0] y, z;
  logic [15:0] nn, hl, addr16;
  logic [AW-1:0] maddr;
  logic [7:0] wdata, rdata;

  assign dec = z80sc_pkg::decode(ir_r);
  assign y = ir_r[5:3];
  assign z = ir_r[2:0];
  assign nn = {hi_r, lo_r};
  assign hl = {h_r, l_r};

  assign sts.dec = dec;
  assign sts.halted = halt_r;
  assign sts.clr_last = (clr_r == AW'(MemBytes - 1));

  function automatic logic [7:0] szp(input logic [7:0] v);
    logic [7:0] f;
    f = 8'h00;
    if (v[7]) f = f | z80sc_pkg::FL_S;
    if (v == 8'h00) f = f | z80sc_pkg::FL_Z;
    if (!(^v)) f = f | z80sc_pkg::FL_PV;
    return f;
  endfunction

  // result in [15:8], flags in [7:0]
  function automatic logic [15:0] alu(input logic [7:0] a, input logic [7:0] v,
                                      input logic [2:0] op);
    logic [8:0] s;
    logic [7:0] r, f;
    s = 9'h000;
    r = 8'h00;
    f = 8'h00;
    unique case (op)
      z80sc_pkg::ALU_ADD: begin
        s = {1'b0, a} + {1'b0, v};
        r = s[7:0];
        f = szp(r) & (z80sc_pkg::FL_S | z80sc_pkg::FL_Z);
        if ({1'b0, a[3:0]} + {1'b0, v[3:0]} > 5'h0f) f = f | z80sc_pkg::FL_H;
        if (((a ^ r) & (v ^ r) & 8'h80) != 8'h00) f = f | z80sc_pkg::FL_PV;
        if (s[8]) f = f | z80sc_pkg::FL_C;
      end
      z80sc_pkg::ALU_AND: begin
        r = a & v;
        f = szp(r) | z80sc_pkg::FL_H;
      end
      z80sc_pkg::ALU_XOR: begin
        r = a ^ v;
        f = szp(r);
      end
      z80sc_pkg::ALU_OR: begin
        r = a | v;
        f = szp(r);
      end
      default: begin
        r = a - v;
        f = (szp(r) & (z80sc_pkg::FL_S | z80sc_pkg::FL_Z)) | z80sc_pkg::FL_N;
        if (a[3:0] < v[3:0]) f = f | z80sc_pkg::FL_H;
        if (((a ^ v) & (a ^ r) & 8'h80) != 8'h00) f = f | z80sc_pkg::FL_PV;
        if (a < v) f = f | z80sc_pkg::FL_C;
      end
    endcase
    return {r, f};
  endfunction

  function automatic logic [7:0] get_r(input logic [2:0] code, input logic [7:0] bb,
                                       input logic [7:0] cc, input logic [7:0] dd,
                                       input logic [7:0] ee, input logic [7:0] hh,
                                       input logic [7:0] ll, input logic [7:0] mm,
                                       input logic [7:0] aa);
    logic [7:0] v;
    unique case (code)
      3'd0: v = bb;
      3'd1: v = cc;
      3'd2: v = dd;
      3'd3: v = ee;
      3'd4: v = hh;
      3'd5: v = ll;
      3'd6: v = mm;
      default: v = aa;
    endcase
    return v;
  endfunction

  logic [7:0] src_z, src_y, incdec_v, idf, res_v, alu_in, rw_val, f_val;
  logic [15:0] alu_o, pc_val, jr_tgt;
  logic rw_en, f_we, pc_we, ld16_we, halt_set, jp_take, jr_take;
  logic [2:0] rw_code, alu_op;
  logic [4:0] cyc_v;
  logic flt_v, iord_v, iowr_v;
  logic [7:0] port_v, wdat_v;

  assign src_z = get_r(z, b_r, c_r, d_r, e_r, h_r, l_r, mdr_r, a_r);
  assign src_y = get_r(y, b_r, c_r, d_r, e_r, h_r, l_r, mdr_r, a_r);
  assign jr_tgt = pc_r + {{8{lo_r[7]}}, lo_r};

  always_comb begin
    logic [7:0] cm;
    unique case (y[2:1])
      2'd0: cm = z80sc_pkg::FL_Z;
      2'd1: cm = z80sc_pkg::FL_C;
      2'd2: cm = z80sc_pkg::FL_PV;
      default: cm = z80sc_pkg::FL_S;
    endcase
    jp_take = ((f_r & cm) != 8'h00) == y[0];
    jr_take = ((f_r & (ir_r[4] ? z80sc_pkg::FL_C : z80sc_pkg::FL_Z)) != 8'h00) == ir_r[3];
  end

  // INC and DEC: parity, then overflow on the old value
  always_comb begin
    if (!ir_r[0]) begin
      incdec_v = src_y + 8'd1;
      idf = (f_r & z80sc_pkg::FL_C) | szp(incdec_v);
      if (src_y[3:0] == 4'hf) idf = idf | z80sc_pkg::FL_H;
      if (src_y == 8'h7f) idf = idf | z80sc_pkg::FL_PV;
    end else begin
      incdec_v = src_y - 8'd1;
      idf = (f_r & z80sc_pkg::FL_C) | szp(incdec_v) | z80sc_pkg::FL_N;
      if (src_y[3:0] == 4'h0) idf = idf | z80sc_pkg::FL_H;
      if (src_y == 8'h80) idf = idf | z80sc_pkg::FL_PV;
    end
  end

  assign alu_in = (dec.cls == z80sc_pkg::C_ALUI) ? lo_r : src_z;
  assign alu_op = y;
  assign alu_o = alu(a_r, alu_in, alu_op);

  always_comb begin
    rw_en = 1'b0;
    rw_code = y;
    rw_val = 8'h00;
    res_v = 8'h00;
    f_we = 1'b0;
    f_val = f_r;
    pc_we = 1'b0;
    pc_val = pc_r;
    ld16_we = 1'b0;
    halt_set = 1'b0;
    cyc_v = 5'd0;
    flt_v = 1'b0;
    iord_v = 1'b0;
    iowr_v = 1'b0;
    port_v = 8'h00;
    wdat_v = 8'h00;
    unique case (dec.cls)
      z80sc_pkg::C_NOP: cyc_v = 5'd4;
      z80sc_pkg::C_HALT: begin
        halt_set = 1'b1;
        cyc_v = 5'd4;
      end
      z80sc_pkg::C_LDRN: begin
        res_v = lo_r;
        rw_en = (y != z80sc_pkg::R_HL_MEM);
        rw_val = lo_r;
        cyc_v = (y == z80sc_pkg::R_HL_MEM) ? 5'd10 : 5'd7;
      end
      z80sc_pkg::C_INCDEC: begin
        res_v = incdec_v;
        rw_en = (y != z80sc_pkg::R_HL_MEM);
        rw_val = incdec_v;
        f_we = 1'b1;
        f_val = idf;
        cyc_v = (y == z80sc_pkg::R_HL_MEM) ? 5'd11 : 5'd4;
      end
      z80sc_pkg::C_LDRR: begin
        res_v = src_z;
        rw_en = (y != z80sc_pkg::R_HL_MEM);
        rw_val = src_z;
        cyc_v = (y == z80sc_pkg::R_HL_MEM || z == z80sc_pkg::R_HL_MEM) ? 5'd7 : 5'd4;
      end
      z80sc_pkg::C_ALU, z80sc_pkg::C_ALUI: begin
        rw_en = (y != z80sc_pkg::ALU_CP);
        rw_code = z80sc_pkg::R_A;
        rw_val = alu_o[15:8];
        f_we = 1'b1;
        f_val = alu_o[7:0];
        cyc_v = (dec.cls == z80sc_pkg::C_ALUI || z == z80sc_pkg::R_HL_MEM) ? 5'd7 : 5'd4;
      end
      z80sc_pkg::C_LD16: begin
        ld16_we = 1'b1;
        cyc_v = 5'd10;
      end
      z80sc_pkg::C_LDAM: begin
        rw_en = 1'b1;
        rw_code = z80sc_pkg::R_A;
        rw_val = mdr_r;
        cyc_v = 5'd13;
      end
      z80sc_pkg::C_LDMA: cyc_v = 5'd13;
      z80sc_pkg::C_JP, z80sc_pkg::C_RET: begin
        pc_we = 1'b1;
        pc_val = nn;
        cyc_v = 5'd10;
      end
      z80sc_pkg::C_JPCC: begin
        pc_we = jp_take;
        pc_val = nn;
        cyc_v = 5'd10;
      end
      z80sc_pkg::C_JR: begin
        pc_we = 1'b1;
        pc_val = jr_tgt;
        cyc_v = 5'd12;
      end
      z80sc_pkg::C_JRCC: begin
        pc_we = jr_take;
        pc_val = jr_tgt;
        cyc_v = jr_take ? 5'd12 : 5'd7;
      end
      z80sc_pkg::C_CALL: cyc_v = 5'd17;
      z80sc_pkg::C_IN: begin
        rw_en = 1'b1;
        rw_code = z80sc_pkg::R_A;
        rw_val = iod_r;
        iord_v = 1'b1;
        port_v = lo_r;
        cyc_v = 5'd11;
      end
      z80sc_pkg::C_OUT: begin
        iowr_v = 1'b1;
        port_v = lo_r;
        wdat_v = a_r;
        cyc_v = 5'd11;
      end
      default: begin
        halt_set = 1'b1;
        flt_v = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.asel)
      z80sc_pkg::AS_PC:   addr16 = pc_r;
      z80sc_pkg::AS_HL:   addr16 = hl;
      z80sc_pkg::AS_NN:   addr16 = nn;
      z80sc_pkg::AS_SP:   addr16 = sp_r;
      z80sc_pkg::AS_SPM1: addr16 = sp_r - 16'd1;
      z80sc_pkg::AS_LOAD: addr16 = in_load_address;
      default:            addr16 = 16'h0000;
    endcase
    maddr = (cmd.asel == z80sc_pkg::AS_CLR) ? clr_r : addr16[AW-1:0];
    unique case (cmd.wsel)
      z80sc_pkg::WD_LOAD: wdata = in_load_data;
      z80sc_pkg::WD_RES:  wdata = res_v;
      z80sc_pkg::WD_A:    wdata = a_r;
      z80sc_pkg::WD_PCH:  wdata = pc_r[15:8];
      z80sc_pkg::WD_PCL:  wdata = pc_r[7:0];
      default:            wdata = 8'h00;
    endcase
  end

  z80sc_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk  (clk),
    .we   (cmd.mem_wr),
    .addr (maddr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'h00; f_r <= 8'h00;
      b_r <= 8'h00; c_r <= 8'h00; d_r <= 8'h00; e_r <= 8'h00;
      h_r <= 8'h00; l_r <= 8'h00;
      pc_r <= z80sc_pkg::ResetPcDef;
      sp_r <= z80sc_pkg::ResetSpDef;
      halt_r <= 1'b0;
      clr_r <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
      if (cfg_we) begin
        if (cfg_idx == z80sc_pkg::CFG_RESET_PC) pc_r <= cfg_wdata;
        else sp_r <= cfg_wdata;
      end
      if (cmd.pc_inc) pc_r <= pc_r + 16'd1;
      if (cmd.sp_inc) sp_r <= sp_r + 16'd1;
      if (cmd.sp_dec) sp_r <= sp_r - 16'd1;
      if (cmd.call_jump) pc_r <= nn;
      if (cmd.exec) begin
        if (pc_we) pc_r <= pc_val;
        if (halt_set) halt_r <= 1'b1;
        if (f_we) f_r <= f_val;
        if (rw_en) begin
          unique case (rw_code)
            3'd0: b_r <= rw_val;
            3'd1: c_r <= rw_val;
            3'd2: d_r <= rw_val;
            3'd3: e_r <= rw_val;
            3'd4: h_r <= rw_val;
            3'd5: l_r <= rw_val;
            3'd7: a_r <= rw_val;
            default: a_r <= a_r;
          endcase
        end
        if (ld16_we) begin
          unique case (ir_r[5:4])
            2'd0: begin b_r <= hi_r; c_r <= lo_r; end
            2'd1: begin d_r <= hi_r; e_r <= lo_r; end
            2'd2: begin h_r <= hi_r; l_r <= lo_r; end
            default: sp_r <= nn;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.lat)
      z80sc_pkg::LAT_IR:  ir_r <= rdata;
      z80sc_pkg::LAT_LO:  lo_r <= rdata;
      z80sc_pkg::LAT_HI:  hi_r <= rdata;
      z80sc_pkg::LAT_MDR: mdr_r <= rdata;
      default: mdr_r <= mdr_r;
    endcase
    if (cmd.start) begin
      iod_r <= in_io_read_data;
      cyc_r <= 5'd0;
      flt_r <= 1'b0;
      iord_r <= 1'b0;
      iowr_r <= 1'b0;
      port_r <= 8'h00;
      wdat_r <= 8'h00;
    end
    if (cmd.exec) begin
      cyc_r <= cyc_v;
      flt_r <= flt_v;
      iord_r <= iord_v;
      iowr_r <= iowr_v;
      port_r <= port_v;
      wdat_r <= wdat_v;
    end
    if (cmd.out_load) begin
      o_cyc_r <= cyc_r;
      o_halt_r <= halt_r;
      o_flt_r <= flt_r;
      o_iord_r <= iord_r;
      o_iowr_r <= iowr_r;
      o_port_r <= port_r;
      o_wdat_r <= wdat_r;
      o_pc_r <= pc_r;
    end
  end

  assign out_cycles = o_cyc_r;
  assign out_halted = o_halt_r;
  assign out_fault = o_flt_r;
  assign out_io_read_done = o_iord_r;
  assign out_io_write_valid = o_iowr_r;
  assign out_io_port = o_port_r;
  assign out_io_write_data = o_wdat_r;
  assign out_pc_now = o_pc_r;

endmodule

/* hw/rtl/z80_subset_cpu_core.sv */
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   opcode, load_address, load_data, io_read_data
// out_     output     out_valid/out_stall cycles, halted, fault, io_*, pc_now
// cfg_     input      cfg_we              cfg_idx selects reset_pc or reset_sp
//
// A load transaction or a step on a halted core goes from idle straight to the done state;
// an instruction takes one state per access of the single-port memory plus decode and execute.
// After reset a clearing pass writes zero to all MemBytes entries, one per clock,
// before the first transaction is taken. MemBytes must be a power of two, unchecked.
// A finished result waits in the output register while the next transaction runs.
module z80_subset_cpu_core #(
  parameter int MemBytes = z80sc_pkg::MemBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_data,
  input  logic [7:0]  in_io_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_cycles,
  output logic        out_halted,
  output logic        out_fault,
  output logic        out_io_read_done,
  output logic        out_io_write_valid,
  output logic [7:0]  out_io_port,
  output logic [7:0]  out_io_write_data,
  output logic [15:0] out_pc_now,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata
);

  z80sc_pkg::cmd_t cmd;
  z80sc_pkg::sts_t sts;

  z80sc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  z80sc_dp #(.MemBytes(MemBytes)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_load_address   (in_load_address),
    .in_load_data      (in_load_data),
    .in_io_read_data   (in_io_read_data),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .out_cycles        (out_cycles),
    .out_halted        (out_halted),
    .out_fault         (out_fault),
    .out_io_read_done  (out_io_read_done),
    .out_io_write_valid(out_io_write_valid),
    .out_io_port       (out_io_port),
    .out_io_write_data (out_io_write_data),
    .out_pc_now        (out_pc_now)
  );

endmodule

/* dv/z80_subset_cpu_core_tb.sv */
module z80_subset_cpu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 300000;
  localparam int ItemTarget = 1250;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_DI      = 8'hf3;
  localparam logic [7:0] OP_EI      = 8'hfb;
  localparam logic [7:0] OP_HALT    = 8'h76;
  localparam logic [7:0] OP_LD_BC   = 8'h01;
  localparam logic [7:0] OP_LD_DE   = 8'h11;
  localparam logic [7:0] OP_LD_HL   = 8'h21;
  localparam logic [7:0] OP_LD_SP   = 8'h31;
  localparam logic [7:0] OP_LD_A_NN = 8'h3a;
  localparam logic [7:0] OP_LD_NN_A = 8'h32;
  localparam logic [7:0] OP_JP      = 8'hc3;
  localparam logic [7:0] OP_JR      = 8'h18;
  localparam logic [7:0] OP_CALL    = 8'hcd;
  localparam logic [7:0] OP_RET     = 8'hc9;
  localparam logic [7:0] OP_ADD_N   = 8'hc6;
  localparam logic [7:0] OP_SUB_N   = 8'hd6;
  localparam logic [7:0] OP_AND_N   = 8'he6;
  localparam logic [7:0] OP_XOR_N   = 8'hee;
  localparam logic [7:0] OP_OR_N    = 8'hf6;
  localparam logic [7:0] OP_CP_N    = 8'hfe;
  localparam logic [7:0] OP_IN      = 8'hdb;
  localparam logic [7:0] OP_OUT     = 8'hd3;
  localparam logic [7:0] OP_LD_A_N  = 8'h3e;
  localparam logic [7:0] OP_INC_A   = 8'h3c;
  localparam logic [7:0] OP_DEC_A   = 8'h3d;
  localparam logic [7:0] JPCC_MASK  = 8'hc7;
  localparam logic [7:0] JPCC_BASE  = 8'hc2;
  localparam logic [7:0] JRCC_MASK  = 8'he7;
  localparam logic [7:0] JRCC_BASE  = 8'h20;
  localparam logic [7:0] LDRN_MASK  = 8'hc7;
  localparam logic [7:0] LDRN_BASE  = 8'h06;
  localparam logic [7:0] INCDEC_MASK = 8'hc6;
  localparam logic [7:0] INCDEC_BASE = 8'h04;

  localparam logic IT_STEP = 1'b0;
  localparam logic IT_LOAD = 1'b1;

  typedef struct packed {
    logic [4:0]  cycles;
    logic        halted;
    logic        fault;
    logic        rd_done;
    logic        wr_valid;
    logic [7:0]  port;
    logic [7:0]  wdata;
    logic [15:0] pc;
  } core_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [15:0] in_load_address = '0;
  logic [7:0]  in_load_data = '0;
  logic [7:0]  in_io_read_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_cycles;
  logic        out_halted;
  logic        out_fault;
  logic        out_io_read_done;
  logic        out_io_write_valid;
  logic [7:0]  out_io_port;
  logic [7:0]  out_io_write_data;
  logic [15:0] out_pc_now;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_wdata = '0;

  z80_subset_cpu_core u_dut (.*);

  always #4 clk = ~clk;

  // shadow copy of the core
  logic [7:0]  shadow_mem [65536];
  logic [7:0]  gpr [8];
  logic [7:0]  flg;
  logic [15:0] pc_q, sp_q;
  logic        halt_q;

  core_result_t expected_results[$];
  int items_sent, steps_sent, loads_sent, results_seen, mismatches;
  int idle_cycles;

  function automatic logic [7:0] sz_par(input logic [7:0] v);
    logic [7:0] f;
    f = '0;
    if (v[7]) f |= z80sc_pkg::FL_S;
    if (v == 8'h00) f |= z80sc_pkg::FL_Z;
    if (!(^v)) f |= z80sc_pkg::FL_PV;
    return f;
  endfunction

  function automatic bit op_supported(input logic [7:0] op);
    if (op == OP_HALT) return 1'b1;
    if ((op & LDRN_MASK) == LDRN_BASE || (op & INCDEC_MASK) == INCDEC_BASE) return 1'b1;
    if (op[7:6] == 2'b01) return 1'b1;
    if (op[7:6] == 2'b10 && op[5:3] != 3'd1 && op[5:3] != 3'd3) return 1'b1;
    if ((op & JPCC_MASK) == JPCC_BASE || (op & JRCC_MASK) == JRCC_BASE) return 1'b1;
    unique case (op)
      OP_NOP, OP_DI, OP_EI, OP_LD_BC, OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_LD_A_NN,
      OP_LD_NN_A, OP_JP, OP_JR, OP_CALL, OP_RET, OP_ADD_N, OP_SUB_N, OP_AND_N,
      OP_XOR_N, OP_OR_N, OP_CP_N, OP_IN, OP_OUT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int operand_bytes(input logic [7:0] op);
    if ((op & LDRN_MASK) == LDRN_BASE || (op & JRCC_MASK) == JRCC_BASE) return 1;
    if ((op & JPCC_MASK) == JPCC_BASE) return 2;
    unique case (op)
      OP_LD_BC, OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_LD_A_NN, OP_LD_NN_A, OP_JP,
      OP_CALL: return 2;
      OP_JR, OP_ADD_N, OP_SUB_N, OP_AND_N, OP_XOR_N, OP_OR_N, OP_CP_N, OP_IN,
      OP_OUT: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] gpr_fetch(input logic [2:0] code);
    return (code == z80sc_pkg::R_HL_MEM) ? shadow_mem[{gpr[4], gpr[5]}] : gpr[code];
  endfunction

  task automatic gpr_store(input logic [2:0] code, input logic [7:0] v);
    if (code == z80sc_pkg::R_HL_MEM) shadow_mem[{gpr[4], gpr[5]}] = v;
    else gpr[code] = v;
  endtask

  task automatic fetch_byte(output logic [7:0] v);
    v = shadow_mem[pc_q];
    pc_q = pc_q + 16'd1;
  endtask

  task automatic fetch_word(output logic [15:0] w);
    logic [7:0] lo, hi;
    fetch_byte(lo);
    fetch_byte(hi);
    w = {hi, lo};
  endtask

  task automatic alu_apply(input logic [2:0] sel, input logic [7:0] v);
    logic [7:0] a, r;
    logic [8:0] s;
    a = gpr[z80sc_pkg::R_A];
    unique case (sel)
      z80sc_pkg::ALU_ADD: begin
        s = {1'b0, a} + {1'b0, v};
        r = s[7:0];
        flg = '0;
        if (r[7]) flg |= z80sc_pkg::FL_S;
        if (r == 8'h00) flg |= z80sc_pkg::FL_Z;
        if ({1'b0, a[3:0]} + {1'b0, v[3:0]} > 5'h0f) flg |= z80sc_pkg::FL_H;
        if (((a ^ r) & (v ^ r)) & 8'h80) flg |= z80sc_pkg::FL_PV;
        if (s[8]) flg |= z80sc_pkg::FL_C;
        gpr[z80sc_pkg::R_A] = r;
      end
      z80sc_pkg::ALU_SUB, z80sc_pkg::ALU_CP: begin
        r = a - v;
        flg = z80sc_pkg::FL_N;
        if (r[7]) flg |= z80sc_pkg::FL_S;
        if (r == 8'h00) flg |= z80sc_pkg::FL_Z;
        if (a[3:0] < v[3:0]) flg |= z80sc_pkg::FL_H;
        if (((a ^ v) & (a ^ r)) & 8'h80) flg |= z80sc_pkg::FL_PV;
        if (a < v) flg |= z80sc_pkg::FL_C;
        if (sel == z80sc_pkg::ALU_SUB) gpr[z80sc_pkg::R_A] = r;
      end
      z80sc_pkg::ALU_AND: begin
        gpr[z80sc_pkg::R_A] = a & v;
        flg = sz_par(a & v) | z80sc_pkg::FL_H;
      end
      z80sc_pkg::ALU_XOR: begin gpr[z80sc_pkg::R_A] = a ^ v; flg = sz_par(a ^ v); end
      default: begin gpr[z80sc_pkg::R_A] = a | v; flg = sz_par(a | v); end
    endcase
  endtask

  task automatic predict_core_result(input logic kind, input logic [15:0] la,
                                     input logic [7:0] ld, input logic [7:0] iord,
                                     output core_result_t r);
    logic [7:0]  op, v, old, m;
    logic [2:0]  y, z;
    logic [15:0] w;
    bit          take;
    r = '0;
    if (kind == IT_LOAD) begin
      shadow_mem[la] = ld;
    end else if (!halt_q) begin
      fetch_byte(op);
      y = op[5:3];
      z = op[2:0];
      if (op == OP_HALT) begin
        halt_q = 1'b1;
        r.cycles = 5'd4;
      end else if ((op & LDRN_MASK) == LDRN_BASE) begin
        fetch_byte(v);
        gpr_store(y, v);
        r.cycles = (y == z80sc_pkg::R_HL_MEM) ? 5'd10 : 5'd7;
      end else if ((op & INCDEC_MASK) == INCDEC_BASE) begin
        old = gpr_fetch(y);
        v = op[0] ? old - 8'd1 : old + 8'd1;
        m = (flg & z80sc_pkg::FL_C) | sz_par(v);
        gpr_store(y, v);
        if (!op[0]) begin
          if (old[3:0] == 4'hf) m |= z80sc_pkg::FL_H;
          if (old == 8'h7f) m |= z80sc_pkg::FL_PV;
        end else begin
          m |= z80sc_pkg::FL_N;
          if (old[3:0] == 4'h0) m |= z80sc_pkg::FL_H;
          if (old == 8'h80) m |= z80sc_pkg::FL_PV;
        end
        flg = m;
        r.cycles = (y == z80sc_pkg::R_HL_MEM) ? 5'd11 : 5'd4;
      end else if (op[7:6] == 2'b01) begin
        gpr_store(y, gpr_fetch(z));
        r.cycles = (y == z80sc_pkg::R_HL_MEM || z == z80sc_pkg::R_HL_MEM) ? 5'd7 : 5'd4;
      end else if (op[7:6] == 2'b10 && y != 3'd1 && y != 3'd3) begin
        alu_apply(y, gpr_fetch(z));
        r.cycles = (z == z80sc_pkg::R_HL_MEM) ? 5'd7 : 5'd4;
      end else if ((op & JPCC_MASK) == JPCC_BASE) begin
        fetch_word(w);
        unique case (y[2:1])
          2'd0: m = z80sc_pkg::FL_Z;
          2'd1: m = z80sc_pkg::FL_C;
          2'd2: m = z80sc_pkg::FL_PV;
          default: m = z80sc_pkg::FL_S;
        endcase
        take = ((flg & m) != 8'h00) == y[0];
        if (take) pc_q = w;
        r.cycles = 5'd10;
      end else if ((op & JRCC_MASK) == JRCC_BASE) begin
        fetch_byte(v);
        m = op[4] ? z80sc_pkg::FL_C : z80sc_pkg::FL_Z;
        take = ((flg & m) != 8'h00) == op[3];
        if (take) pc_q = pc_q + {{8{v[7]}}, v};
        r.cycles = take ? 5'd12 : 5'd7;
      end else begin
        unique case (op)
          OP_NOP, OP_DI, OP_EI: r.cycles = 5'd4;
          OP_LD_BC, OP_LD_DE, OP_LD_HL: begin
            fetch_word(w);
            gpr[{op[5:4], 1'b0}] = w[15:8];
            gpr[{op[5:4], 1'b1}] = w[7:0];
            r.cycles = 5'd10;
          end
          OP_LD_SP: begin fetch_word(w); sp_q = w; r.cycles = 5'd10; end
          OP_LD_A_NN: begin
            fetch_word(w);
            gpr[z80sc_pkg::R_A] = shadow_mem[w];
            r.cycles = 5'd13;
          end
          OP_LD_NN_A: begin
            fetch_word(w);
            shadow_mem[w] = gpr[z80sc_pkg::R_A];
            r.cycles = 5'd13;
          end
          OP_JP: begin fetch_word(w); pc_q = w; r.cycles = 5'd10; end
          OP_JR: begin
            fetch_byte(v);
            pc_q = pc_q + {{8{v[7]}}, v};
            r.cycles = 5'd12;
          end
          OP_CALL: begin
            fetch_word(w);
            sp_q = sp_q - 16'd1;
            shadow_mem[sp_q] = pc_q[15:8];
            sp_q = sp_q - 16'd1;
            shadow_mem[sp_q] = pc_q[7:0];
            pc_q = w;
            r.cycles = 5'd17;
          end
          OP_RET: begin
            w[7:0] = shadow_mem[sp_q];
            sp_q = sp_q + 16'd1;
            w[15:8] = shadow_mem[sp_q];
            sp_q = sp_q + 16'd1;
            pc_q = w;
            r.cycles = 5'd10;
          end
          OP_ADD_N, OP_SUB_N, OP_AND_N, OP_XOR_N, OP_OR_N, OP_CP_N: begin
            fetch_byte(v);
            alu_apply(y, v);
            r.cycles = 5'd7;
          end
          OP_IN: begin
            fetch_byte(r.port);
            gpr[z80sc_pkg::R_A] = iord;
            r.rd_done = 1'b1;
            r.cycles = 5'd11;
          end
          OP_OUT: begin
            fetch_byte(r.port);
            r.wdata = gpr[z80sc_pkg::R_A];
            r.wr_valid = 1'b1;
            r.cycles = 5'd11;
          end
          default: begin
            halt_q = 1'b1;
            r.fault = 1'b1;
          end
        endcase
      end
    end
    r.halted = halt_q;
    r.pc = pc_q;
  endtask

  // predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    core_result_t exp_r, got_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_r = '{out_cycles, out_halted, out_fault, out_io_read_done, out_io_write_valid,
                  out_io_port, out_io_write_data, out_pc_now};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result with nothing expected: %p", got_r);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: cyc %0d/%0d halt %b/%b fault %b/%b rd %b/%b wr %b/%b",
                        " port %h/%h wd %h/%h pc %h/%h (exp/got)"},
                       exp_r.cycles, got_r.cycles, exp_r.halted, got_r.halted,
                       exp_r.fault, got_r.fault, exp_r.rd_done, got_r.rd_done,
                       exp_r.wr_valid, got_r.wr_valid, exp_r.port, got_r.port,
                       exp_r.wdata, got_r.wdata, exp_r.pc, got_r.pc);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_core_result(in_opcode, in_load_address, in_load_data, in_io_read_data, exp_r);
        expected_results.push_back(exp_r);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: %0d results still pending", expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure: free-running stretches, short stalls, rare long ones
  always @(negedge clk) begin
    int run_left, pick;
    if (run_left > 0) begin
      run_left--;
    end else begin
      pick = $urandom_range(99);
      if (pick < 55) begin out_stall = 1'b0; run_left = $urandom_range(30, 1); end
      else if (pick < 93) begin out_stall = 1'b1; run_left = $urandom_range(3, 1); end
      else begin out_stall = 1'b1; run_left = $urandom_range(40, 10); end
    end
  end

  // starts and ends at a falling edge
  task automatic send_item(input logic kind, input logic [15:0] la, input logic [7:0] ld,
                           input logic [7:0] iord);
    int gap, pick;
    pick = $urandom_range(99);
    gap = (pick < 50) ? 0 : (pick < 92) ? $urandom_range(3, 1) : $urandom_range(30, 5);
    repeat (gap) @(negedge clk);
    in_opcode = kind;
    in_load_address = la;
    in_load_data = ld;
    in_io_read_data = iord;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
    if (kind == IT_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  task automatic load_byte(input logic [15:0] a, input logic [7:0] d);
    send_item(IT_LOAD, a, d, 8'($urandom));
  endtask

  task automatic step_core(input logic [7:0] iord);
    send_item(IT_STEP, 16'($urandom), 8'($urandom), iord);
  endtask

  // place an instruction at the current program counter, then execute it
  task automatic run_insn(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2,
                          input logic [7:0] iord);
    logic [15:0] at;
    int n;
    at = pc_q;
    n = operand_bytes(op);
    load_byte(at, op);
    if (n > 0) load_byte(at + 16'd1, b1);
    if (n > 1) load_byte(at + 16'd2, b2);
    step_core(iord);
  endtask

  task automatic drain;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == z80sc_pkg::CFG_RESET_PC) pc_q = val;
    else sp_q = val;
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    logic [7:0] rare [12] = '{OP_CALL, OP_RET, OP_IN, OP_OUT, OP_JP, OP_JR, JPCC_BASE,
                              JRCC_BASE, OP_LD_A_NN, OP_LD_NN_A, OP_LD_HL, OP_LD_SP};
    if ($urandom_range(99) < 40) begin
      op = rare[$urandom_range(11)];
      if (op == JPCC_BASE) op = op | {2'b00, 3'($urandom), 3'b000};
      if (op == JRCC_BASE) op = op | {3'b000, 2'($urandom), 3'b000};
      return op;
    end
    do op = 8'($urandom); while (!op_supported(op) || op == OP_HALT);
    return op;
  endfunction

  task automatic test_directed;
    write_cfg(z80sc_pkg::CFG_RESET_PC, 16'h0000);
    write_cfg(z80sc_pkg::CFG_RESET_SP, 16'hffff);
    load_byte(16'hffff, 8'hff);
    run_insn(OP_LD_A_N, 8'h7f, 8'h00, 8'h00);
    run_insn(OP_INC_A, 8'h00, 8'h00, 8'hff);
    run_insn(OP_DEC_A, 8'h00, 8'h00, 8'h00);
    run_insn(OP_ADD_N, 8'hff, 8'h00, 8'h00);
    run_insn(OP_OUT, 8'hff, 8'h00, 8'h00);
    run_insn(OP_IN, 8'h00, 8'h00, 8'hff);
    run_insn(OP_AND_N, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random_programs(input int item_goal);
    int pick;
    logic [7:0] op;
    while (items_sent < item_goal) begin
      pick = $urandom_range(99);
      op = shadow_mem[pc_q];
      if (pick < 10) begin
        load_byte(16'($urandom), 8'($urandom));
      end else if (pick < 22 && op_supported(op) && op != OP_HALT) begin
        step_core(8'($urandom));
      end else if (pick < 27) begin
        // opcode only, operands are whatever memory holds
        load_byte(pc_q, pick_opcode());
        step_core(8'($urandom));
      end else begin
        run_insn(pick_opcode(), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_config_phases;
    logic [15:0] pcs [6] = '{16'hffff, 16'h0000, 16'h8000, 16'hfffe, 16'h1234, 16'h7fff};
    logic [15:0] sps [6] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'hfff0, 16'h4000};
    for (int i = 0; i < 8; i++) begin
      write_cfg(z80sc_pkg::CFG_RESET_PC, (i < 6) ? pcs[i] : 16'($urandom));
      write_cfg(z80sc_pkg::CFG_RESET_SP, (i < 6) ? sps[i] : 16'($urandom));
      test_random_programs(30 + (ItemTarget - 40) * (i + 1) / 8);
    end
  endtask

  // the core stays halted until reset, so this runs last
  task automatic test_halt_end;
    logic [7:0] op;
    if ($urandom_range(1)) begin
      run_insn(OP_HALT, 8'h00, 8'h00, 8'h00);
    end else begin
      do op = 8'($urandom); while (op_supported(op));
      run_insn(op, 8'h00, 8'h00, 8'h00);
    end
    step_core(8'($urandom));
    load_byte(16'($urandom), 8'($urandom));
    step_core(8'($urandom));
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) shadow_mem[i] = 8'h00;
    foreach (gpr[i]) gpr[i] = 8'h00;
    flg = '0;
    pc_q = z80sc_pkg::ResetPcDef;
    sp_q = z80sc_pkg::ResetSpDef;
    halt_q = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_phases();
    test_halt_end();
    drain();
    $display("covered %0d transactions: %0d steps, %0d byte loads, %0d results checked",
             items_sent, steps_sent, loads_sent, results_seen);
    $display("eight reset_pc/reset_sp settings incl. extremes; run ended in halt state");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/z80sc_pkg.sv
hw/rtl/z80sc_ram.sv
hw/rtl/z80sc_ctrl.sv
hw/rtl/z80sc_dp.sv
hw/rtl/z80_subset_cpu_core.sv
dv/z80_subset_cpu_core_tb.sv
